### src/hcd_pkg.sv
// Shared types and constants for the chunked transfer decoder.
`default_nettype none

package hcd_pkg;

  localparam int SIZE_BITS   = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_TRAILER = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY    = 2'd0,
    KIND_TRAILER = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

endpackage

`default_nettype wire

### src/hcd_front.sv
// Byte parser: accepts input items, tracks chunk framing and produces result items.
`default_nettype none

module hcd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             new_message,
  output logic                  push,
  output hcd_pkg::result_t      push_res
);

  hcd_pkg::phase_t                 phase, phase_next, ph_eff;
  logic [hcd_pkg::SIZE_BITS-1:0]   remaining, remaining_next, rem_eff, rem_dec;
  logic                            digit_seen, digit_seen_next, seen_eff;
  logic                            hex_ok;
  logic [3:0]                      hex_d;
  logic                            overflow;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  always_comb begin
    ph_eff   = new_message ? hcd_pkg::PH_SIZE : phase;
    rem_eff  = new_message ? '0 : remaining;
    seen_eff = new_message ? 1'b0 : digit_seen;
    {hex_ok, hex_d} = hex_decode(data_byte);
    overflow = (rem_eff[hcd_pkg::SIZE_BITS-1 -: 4] != 4'd0);
    rem_dec  = rem_eff - hcd_pkg::SIZE_BITS'(1);
  end

  always_comb begin
    phase_next      = ph_eff;
    remaining_next  = rem_eff;
    digit_seen_next = seen_eff;
    push            = 1'b0;
    push_res.data   = 8'd0;
    push_res.kind   = hcd_pkg::KIND_ERROR;
    case (ph_eff)
      hcd_pkg::PH_SIZE: begin
        if (hex_ok) begin
          if (overflow) begin
            phase_next = hcd_pkg::PH_ERROR;
            push       = 1'b1;
          end else begin
            remaining_next  = {rem_eff[hcd_pkg::SIZE_BITS-5:0], hex_d};
            digit_seen_next = 1'b1;
          end
        end else if (!seen_eff && (data_byte == hcd_pkg::CH_CR ||
                                   data_byte == hcd_pkg::CH_LF)) begin
          phase_next = hcd_pkg::PH_SIZE;
        end else if (seen_eff && data_byte == hcd_pkg::CH_CR) begin
          phase_next = hcd_pkg::PH_SIZE_LF;
        end else begin
          phase_next = hcd_pkg::PH_ERROR;
          push       = 1'b1;
        end
      end
      hcd_pkg::PH_SIZE_LF: begin
        if (data_byte != hcd_pkg::CH_LF) begin
          phase_next = hcd_pkg::PH_ERROR;
          push       = 1'b1;
        end else begin
          digit_seen_next = 1'b0;
          if (rem_eff == '0) begin
            phase_next    = hcd_pkg::PH_TRAILER;
            push          = 1'b1;
            push_res.kind = hcd_pkg::KIND_END;
          end else begin
            phase_next = hcd_pkg::PH_DATA;
          end
        end
      end
      hcd_pkg::PH_DATA: begin
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = hcd_pkg::PH_DATA_CR;
        end
        push          = 1'b1;
        push_res.data = data_byte;
        push_res.kind = hcd_pkg::KIND_BODY;
      end
      hcd_pkg::PH_DATA_CR: begin
        if (data_byte != hcd_pkg::CH_CR) begin
          phase_next = hcd_pkg::PH_ERROR;
          push       = 1'b1;
        end else begin
          phase_next = hcd_pkg::PH_DATA_LF;
        end
      end
      hcd_pkg::PH_DATA_LF: begin
        if (data_byte != hcd_pkg::CH_LF) begin
          phase_next = hcd_pkg::PH_ERROR;
          push       = 1'b1;
        end else begin
          phase_next      = hcd_pkg::PH_SIZE;
          remaining_next  = '0;
          digit_seen_next = 1'b0;
        end
      end
      hcd_pkg::PH_TRAILER: begin
        push          = 1'b1;
        push_res.data = data_byte;
        push_res.kind = hcd_pkg::KIND_TRAILER;
      end
      default: begin
        phase_next = hcd_pkg::PH_ERROR;
      end
    endcase
    push = push & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= hcd_pkg::PH_SIZE;
      remaining  <= '0;
      digit_seen <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      digit_seen <= digit_seen_next;
    end
  end

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !new_message && phase == hcd_pkg::PH_ERROR |-> !push)
    else $error("result produced in error phase");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == hcd_pkg::PH_DATA |-> remaining != '0)
    else $error("data phase with zero count");

endmodule

`default_nettype wire

### src/hcd_fifo.sv
// Short result queue between the parser and the output stage.
`default_nettype none

module hcd_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire hcd_pkg::result_t push_res,
  input  wire logic             pop,
  output hcd_pkg::result_t      head,
  output logic                  empty,
  output logic                  full
);

  hcd_pkg::result_t                mem [hcd_pkg::QUEUE_DEPTH];
  logic [hcd_pkg::PTR_W-1:0]       wr_ptr, rd_ptr;
  logic [hcd_pkg::CNT_W-1:0]       count;

  assign empty = (count == '0);
  assign full  = (count == hcd_pkg::CNT_W'(hcd_pkg::QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + hcd_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hcd_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + hcd_pkg::CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - hcd_pkg::CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hcd_pkg::CNT_W'(hcd_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

### src/hcd_back.sv
// Output stage: drains the result queue into a registered output item.
`default_nettype none

module hcd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hcd_pkg::result_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic [1:0]            out_kind
);

  hcd_pkg::result_t out_res;

  assign pop      = !empty && (!out_valid || !out_stall);
  assign out_byte = out_res.data;
  assign out_kind = out_res.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= head;
    end
  end

endmodule

`default_nettype wire

### src/http_chunked_decoder.sv
// Top level of the HTTP/1.1 chunked transfer decoder.
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+-----------------------
//  input   | in_valid  | in_stall  | data_byte, new_message
//  output  | out_valid | out_stall | out_byte, out_kind
//
// One input item per cycle while in_stall is low; the parser registers its state on each accepted item.
// A result passes through the result queue and then the registered output stage before it is valid.
// in_stall rises only when the two-entry result queue is full.
// rst (synchronous) returns the parser to a fresh size line and empties the queue.
`default_nettype none

module http_chunked_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       new_message,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind
);

  logic                 accept;
  logic                 push, pop, empty, full;
  hcd_pkg::result_t     push_res, head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  hcd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .new_message (new_message),
    .push        (push),
    .push_res    (push_res)
  );

  hcd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  hcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind)
  );

endmodule

`default_nettype wire
